>>> hdl/colc_pkg.sv
// ----------------------------------------------------------------------------
// colc_pkg: shared definitions for the column occupancy limit checker
// Opcodes, field widths, epoch tag width and the control struct that the
// epoch and sweep controller hands to the top level.
// ----------------------------------------------------------------------------
package colc_pkg;

  localparam int MAX_COLS_DEF   = 4096;
  localparam int COUNT_BITS_DEF = 8;

  localparam int COLUMN_W = 12;
  localparam int LIMIT_W  = 8;
  localparam int OPCODE_W = 2;

  // Width of the epoch tag kept with every count. Tag zero never matches.
  localparam int EPOCH_W = 4;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd2;

  localparam logic [OPCODE_W-1:0] OP_CHECK  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_UPDATE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd2;

  typedef struct packed {
    logic               sweeping;
    logic               at_last_epoch;
    logic [EPOCH_W-1:0] epoch;
  } colc_epoch_t;

endpackage

>>> hdl/column_occupancy_limit_checker.sv
// ----------------------------------------------------------------------------
// column_occupancy_limit_checker: per-column nonzero count and limit check
// Counts nonzeros per column over a group of sparse rows and reports whether
// any column of a checked row already holds the configured limit.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Carries
//   in_*     input      tuser: opcode; tdata: column; tlast: last_in_row
//   out_*    output     tuser: done_opcode; tdata: row_fits
//   cfg_*    input      data: column_limit (always ready)
//
// One item is taken per cycle: it issues its count read as it enters, and its
// read-modify-write completes in stage 1, with a write of the item just ahead
// forwarded to the one behind it. Stage 1 loads each result into the output register.
// After reset a sweep zeroes every tag while in_tready stays low. Every
// fifteenth clear runs out of tags, holds the input back and starts a sweep.
// Apart from these, input stalls only when a result finds the output still full.
//
module column_occupancy_limit_checker
  import colc_pkg::*;
#(
  parameter int MAX_COLS   = MAX_COLS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [11:0] column, [15:12] zero
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  input  logic        in_tlast,   // last_in_row
  // Result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] row_fits, [7:1] zero
  output logic [1:0]  out_tuser,  // [1:0] done_opcode
  // Configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data    // [7:0] column_limit
);

  localparam int ADDR_W = $clog2(MAX_COLS);
  localparam int WORD_W = EPOCH_W + COUNT_BITS;
  localparam int CMP_W  = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;
  localparam logic [COUNT_BITS-1:0] COUNT_SAT = {COUNT_BITS{1'b1}};

  // Configuration register, writable at any time.
  logic [LIMIT_W-1:0] limit_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_valid) begin
      limit_r <= cfg_data;
    end
  end

  // Epoch tags and the clearing sweep.
  colc_epoch_t       ep;
  logic [ADDR_W-1:0] sweep_addr;
  logic              clear_fire;

  colc_epoch #(
    .DEPTH (MAX_COLS)
  ) u_epoch (
    .clk        (clk),
    .rst_n      (rst_n),
    .clear_fire (clear_fire),
    .ctl        (ep),
    .sweep_addr (sweep_addr)
  );

  // Stage 1 holds the item whose count word comes back from the store.
  logic                 s1_valid_r;
  logic [OPCODE_W-1:0]  s1_op_r;
  logic [COLUMN_W-1:0]  s1_col_r;
  logic                 s1_last_r;

  logic                 in_fire;
  logic                 s1_needs_out;
  logic                 s1_advance;
  logic                 s1_fire;
  logic                 clear_blocks;

  logic [ADDR_W-1:0]    in_addr;
  logic [ADDR_W-1:0]    s1_addr;
  logic                 s1_in_range;

  // Row conflict flag shared by the items of a row.
  logic                 conflict_r;

  // Output register.
  logic                 out_valid_r;
  logic                 out_fits_r;
  logic [OPCODE_W-1:0]  out_op_r;

  always_comb begin
    case (s1_op_r)
      OP_CHECK, OP_UPDATE: s1_needs_out = s1_last_r;
      OP_CLEAR:            s1_needs_out = 1'b1;
      default:             s1_needs_out = 1'b0;
    endcase
  end

  assign s1_advance = !s1_valid_r || !s1_needs_out || !out_valid_r || out_tready;
  assign s1_fire    = s1_valid_r && s1_advance;
  assign clear_fire = s1_fire && (s1_op_r == OP_CLEAR);

  // A clear that uses up the last tag starts a sweep next cycle; no item may
  // read the store behind it.
  assign clear_blocks = s1_valid_r && (s1_op_r == OP_CLEAR) && ep.at_last_epoch;

  assign in_tready = !ep.sweeping && s1_advance && !clear_blocks;
  assign in_fire   = in_tvalid && in_tready;

  assign in_addr     = ADDR_W'(in_tdata[COLUMN_W-1:0]);
  assign s1_addr     = ADDR_W'(s1_col_r);
  assign s1_in_range = (32'(s1_col_r) < 32'(MAX_COLS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r   <= in_tuser;
      s1_col_r  <= in_tdata[COLUMN_W-1:0];
      s1_last_r <= in_tlast;
    end
  end

  // Count store and its write port. The sweep owns the port while it runs.
  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;
  logic [WORD_W-1:0]    wr_data;
  logic [WORD_W-1:0]    rd_data;
  logic [WORD_W-1:0]    upd_word;

  colc_count_mem #(
    .DEPTH (MAX_COLS),
    .WIDTH (WORD_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (in_fire),
    .rd_addr (in_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    if (ep.sweeping) begin
      wr_en   = 1'b1;
      wr_addr = sweep_addr;
      wr_data = '0;
    end else begin
      wr_en   = s1_fire && (s1_op_r == OP_UPDATE) && s1_in_range;
      wr_addr = s1_addr;
      wr_data = upd_word;
    end
  end

  // The store returns the word as it was at the read edge. The write made at
  // that same edge is kept here and replaces it when the address matches.
  logic                 fwd_valid_r;
  logic [ADDR_W-1:0]    fwd_addr_r;
  logic [WORD_W-1:0]    fwd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else if (in_fire) begin
      fwd_valid_r <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      fwd_addr_r <= wr_addr;
      fwd_data_r <= wr_data;
    end
  end

  // Read-modify-write of the item in stage 1.
  logic [WORD_W-1:0]     cur_word;
  logic [EPOCH_W-1:0]    cur_tag;
  logic [COUNT_BITS-1:0] cur_count;
  logic [COUNT_BITS-1:0] new_count;
  logic                  cur_valid;
  logic                  col_full;

  always_comb begin
    if (fwd_valid_r && (fwd_addr_r == s1_addr)) begin
      cur_word = fwd_data_r;
    end else begin
      cur_word = rd_data;
    end
    cur_tag   = cur_word[WORD_W-1 -: EPOCH_W];
    cur_count = cur_word[COUNT_BITS-1:0];
    cur_valid = s1_in_range && (cur_tag == ep.epoch);
    col_full  = cur_valid && (CMP_W'(cur_count) >= CMP_W'(limit_r));

    if (!cur_valid) begin
      new_count = COUNT_BITS'(1);
    end else if (cur_count == COUNT_SAT) begin
      new_count = cur_count;
    end else begin
      new_count = cur_count + COUNT_BITS'(1);
    end
    upd_word = {ep.epoch, new_count};
  end

  // Row conflict flag: set by a full column of a checked row, cleared by the
  // last item of any row and by a clear.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conflict_r <= 1'b0;
    end else if (s1_fire) begin
      case (s1_op_r)
        OP_CHECK: begin
          if (s1_last_r) begin
            conflict_r <= 1'b0;
          end else if (col_full) begin
            conflict_r <= 1'b1;
          end
        end
        OP_UPDATE: begin
          if (s1_last_r) begin
            conflict_r <= 1'b0;
          end
        end
        OP_CLEAR: conflict_r <= 1'b0;
        default:  conflict_r <= conflict_r;
      endcase
    end
  end

  // Result register. It is loaded only when it is free or being emptied.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_needs_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_needs_out) begin
      out_op_r   <= s1_op_r;
      out_fits_r <= (s1_op_r == OP_CHECK) ? !(conflict_r || col_full) : 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_fits_r};
  assign out_tuser  = out_op_r;

endmodule

>>> hdl/colc_count_mem.sv
// ----------------------------------------------------------------------------
// colc_count_mem: count store
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module colc_count_mem #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 12
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // A read at the address being written returns the old word.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/colc_epoch.sv
// ----------------------------------------------------------------------------
// colc_epoch: epoch tag and clearing sweep controller
// A clear moves to the next epoch so that every stored tag stops matching.
// After reset, and when the tags run out, a sweep writes tag zero everywhere.
// ----------------------------------------------------------------------------
module colc_epoch
  import colc_pkg::*;
#(
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     clear_fire,
  output colc_epoch_t              ctl,
  output logic [$clog2(DEPTH)-1:0] sweep_addr
);

  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};
  localparam logic [ADDR_W-1:0]  ADDR_LAST   = ADDR_W'(DEPTH - 1);

  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic               sweep_r, sweep_nxt;
  logic [ADDR_W-1:0]  sweep_addr_r, sweep_addr_nxt;

  always_comb begin
    epoch_nxt      = epoch_r;
    sweep_nxt      = sweep_r;
    sweep_addr_nxt = sweep_addr_r;
    if (sweep_r) begin
      sweep_addr_nxt = sweep_addr_r + ADDR_W'(1);
      if (sweep_addr_r == ADDR_LAST) begin
        sweep_nxt = 1'b0;
      end
    end else if (clear_fire) begin
      if (epoch_r == EPOCH_LAST) begin
        epoch_nxt      = EPOCH_FIRST;
        sweep_nxt      = 1'b1;
        sweep_addr_nxt = '0;
      end else begin
        epoch_nxt = epoch_r + EPOCH_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_r      <= EPOCH_FIRST;
      sweep_r      <= 1'b1;
      sweep_addr_r <= '0;
    end else begin
      epoch_r      <= epoch_nxt;
      sweep_r      <= sweep_nxt;
      sweep_addr_r <= sweep_addr_nxt;
    end
  end

  assign ctl.sweeping      = sweep_r;
  assign ctl.at_last_epoch = (epoch_r == EPOCH_LAST);
  assign ctl.epoch         = epoch_r;
  assign sweep_addr        = sweep_addr_r;

endmodule

>>> hdl/colc_checker.sv
// ----------------------------------------------------------------------------
// colc_checker: port-level checks for the column occupancy limit checker
// Watches the top level's ports only; attached by the bind below.
// ----------------------------------------------------------------------------
module colc_checker
  import colc_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic [1:0]  out_tuser
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Only check, update and clear ever complete.
  a_out_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == OP_CHECK) || (out_tuser == OP_UPDATE) ||
                   (out_tuser == OP_CLEAR))
    else $error("result carries an opcode that never completes");

  // Update and clear always report that the row fits.
  a_out_fits: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != OP_CHECK) |-> out_tdata[0])
    else $error("update or clear reported a misfit");

  // The store sweep right after reset keeps the input closed.
  a_reset_sweep: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !in_tready)
    else $error("input opened before the store sweep");

endmodule

bind column_occupancy_limit_checker colc_checker u_colc_checker (.*);
